FILE: sv/bdc_pkg.sv
// bdc_pkg: shared types and constants for the button debounce classifier
// no dependencies

`default_nettype none

package bdc_pkg;

   typedef logic [1:0] event_type;

   localparam event_type EV_NONE  = 2'd0;
   localparam event_type EV_PRESS = 2'd1;
   localparam event_type EV_LONG  = 2'd2;

   localparam int unsigned ADDR_W = 3;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned DEB_W  = 16;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DATA_W-1:0] data_type;
   typedef logic [TIME_W-1:0] time_type;
   typedef logic [DEB_W-1:0]  deb_type;

   localparam logic REG_DEBOUNCE = 1'b0;
   localparam logic REG_LONG     = 1'b1;

   localparam deb_type  DEBOUNCE_RESET = 16'd20;
   localparam time_type LONG_RESET     = 32'd1000;

endpackage

`default_nettype wire

FILE: sv/button_debounce_classifier.sv
// button_debounce_classifier: debounce and press classification of timestamped button samples
// depends on bdc_pkg
// a request is registered in the input register at acceptance, its result is then presented from the result register
// throughput: one request per cycle, limited only by the result register being taken
// the state update (two 32-bit subtractions and compares) is combinational
// reset: synchronous, clears all control state and counters, registers return to defaults

`default_nettype none

module button_debounce_classifier (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire                 req_pressed,
   input  wire  [31:0]         req_now_ms,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output bdc_pkg::event_type  rsp_event_res,
   output logic [31:0]         rsp_held_ms,
   output logic [31:0]         rsp_press_total,
   output logic [31:0]         rsp_chatter_total,
   input  wire                 psel,
   input  wire                 penable,
   input  wire                 pwrite,
   input  wire  [2:0]          paddr,
   input  wire  [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import bdc_pkg::*;

   // configuration
   deb_type  deb_ff;
   time_type long_ff;

   // input register
   logic     in_valid_ff;
   logic     in_lvl_ff;
   time_type in_now_ff;

   // classifier state
   logic     seen_ff,      seen_in;
   logic     raw_ff,       raw_in;
   logic     stable_ff,    stable_in;
   time_type raw_at_ff,    raw_at_in;
   time_type press_at_ff,  press_at_in;
   logic     long_done_ff, long_done_in;
   time_type chatter_ff,   chatter_in;
   time_type press_ff,     press_in;

   // result register
   logic      out_valid_ff;
   event_type out_event_ff, out_event_in;
   time_type  out_held_ff,  out_held_in;

   logic     advance;
   logic     cfg_write;
   time_type diff_raw;
   time_type diff_press;
   time_type hold_ms;
   logic     settle;
   logic     level_after;
   logic     long_after;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;
   assign prdata    = (paddr[2] == REG_DEBOUNCE) ? {{(DATA_W-DEB_W){1'b0}}, deb_ff} : long_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff  <= DEBOUNCE_RESET;
         long_ff <= LONG_RESET;
      end else if (cfg_write) begin
         if (paddr[2] == REG_DEBOUNCE) begin
            deb_ff <= pwdata[DEB_W-1:0];
         end else begin
            long_ff <= pwdata;
         end
      end
   end

   assign advance   = ~out_valid_ff | ~rsp_stall;
   assign req_stall = in_valid_ff & ~advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (~req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & ~req_stall) begin
         in_lvl_ff <= req_pressed;
         in_now_ff <= req_now_ms;
      end
   end

   assign diff_raw   = in_now_ff - raw_at_ff;
   assign diff_press = in_now_ff - press_at_ff;
   assign settle     = (raw_ff != stable_ff) && (diff_raw >= {{(TIME_W-DEB_W){1'b0}}, deb_ff});

   always_comb begin
      seen_in      = seen_ff;
      raw_in       = raw_ff;
      stable_in    = stable_ff;
      raw_at_in    = raw_at_ff;
      press_at_in  = press_at_ff;
      long_done_in = long_done_ff;
      chatter_in   = chatter_ff;
      press_in     = press_ff;
      out_event_in = EV_NONE;
      out_held_in  = '0;
      level_after  = stable_ff;
      long_after   = long_done_ff;
      hold_ms      = diff_press;
      if (~seen_ff) begin
         seen_in     = 1'b1;
         raw_in      = in_lvl_ff;
         stable_in   = in_lvl_ff;
         raw_at_in   = in_now_ff;
         press_at_in = in_now_ff;
      end else if (in_lvl_ff != raw_ff) begin
         if (raw_ff != stable_ff) begin
            chatter_in = chatter_ff + 1'b1;
         end
         raw_in    = in_lvl_ff;
         raw_at_in = in_now_ff;
      end else if (settle && ~raw_ff) begin
         // debounced release completes a press
         stable_in    = 1'b0;
         press_in     = press_ff + 1'b1;
         out_event_in = EV_PRESS;
         out_held_in  = diff_press;
      end else begin
         if (settle) begin
            // debounced press starts the hold timer
            stable_in    = 1'b1;
            press_at_in  = in_now_ff;
            long_done_in = 1'b0;
            level_after  = 1'b1;
            long_after   = 1'b0;
            hold_ms      = '0;
         end
         if (level_after && ~long_after && (hold_ms >= long_ff)) begin
            long_done_in = 1'b1;
            out_event_in = EV_LONG;
            out_held_in  = hold_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         raw_ff       <= 1'b0;
         stable_ff    <= 1'b0;
         raw_at_ff    <= '0;
         press_at_ff  <= '0;
         long_done_ff <= 1'b0;
         chatter_ff   <= '0;
         press_ff     <= '0;
      end else if (in_valid_ff & advance) begin
         seen_ff      <= seen_in;
         raw_ff       <= raw_in;
         stable_ff    <= stable_in;
         raw_at_ff    <= raw_at_in;
         press_at_ff  <= press_at_in;
         long_done_ff <= long_done_in;
         chatter_ff   <= chatter_in;
         press_ff     <= press_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff & advance) begin
         out_event_ff <= out_event_in;
         out_held_ff  <= out_held_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_res     = out_event_ff;
   assign rsp_held_ms       = out_held_ff;
   assign rsp_press_total   = press_ff;
   assign rsp_chatter_total = chatter_ff;

   // a long event is only reported while the debounced level is pressed
   a_long_needs_press: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_event_ff == EV_LONG)) |-> (stable_ff && long_done_ff))
      else $error("long event without a held press");

   // a press event leaves the debounced level released
   a_press_released: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_event_ff == EV_PRESS)) |-> ~stable_ff)
      else $error("press event while still held");

   // no event carries no hold time
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_event_ff == EV_NONE)) |-> (out_held_ff == '0))
      else $error("hold time on a result without event");

   // state only moves when a request is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> ($stable(press_ff) && $stable(chatter_ff)))
      else $error("counters changed while the result was stalled");

   // input stage is only stalled while it holds a request
   a_stall_valid: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("request stall with nothing held");

endmodule

`default_nettype wire
